>>> src/ipcp_pkg.sv
// Shared types and constants of the IPv4 CIDR text parser.
`timescale 1ns / 1ps

package ipcp_pkg;

  // Characters that steer the parse.
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharSlash = 8'h2f;

  // Saturation points (one past the largest legal value) and legal limits.
  localparam logic [8:0] PartSat    = 9'd256;
  localparam logic [8:0] PartMax    = 9'd255;
  localparam logic [5:0] PrefixSat  = 6'd33;
  localparam logic [5:0] PrefixMax  = 6'd32;
  localparam logic [15:0] CountMax  = 16'hffff;
  localparam logic [1:0] LastPart   = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ADDR   = 2'd1,
    PH_PREFIX = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_DIGIT_EXP   = 3'd1,
    ST_TOO_MANY    = 3'd2,
    ST_PART_OVER   = 3'd3,
    ST_TOO_FEW     = 3'd4,
    ST_NO_SLASH    = 3'd5,
    ST_PREFIX_OVER = 3'd6
  } status_e;

  typedef struct packed {
    logic [8:0]  part_acc;
    logic [1:0]  parts_done;
    logic [23:0] upper_addr;
    phase_e      phase;
    logic [5:0]  prefix_acc;
    logic        digit_expected;
    logic [15:0] char_count;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    part_acc:       9'd0,
    parts_done:     2'd0,
    upper_addr:     24'd0,
    phase:          PH_IDLE,
    prefix_acc:     6'd0,
    digit_expected: 1'b1,
    char_count:     16'd0
  };

  typedef struct packed {
    status_e     status;
    logic [31:0] address;
    logic [31:0] mask;
    logic [5:0]  prefix_length;
    logic [15:0] consumed_length;
  } result_t;

endpackage

>>> src/ipcp_if.sv
// Valid/ready channel interfaces for the character and result streams.
`timescale 1ns / 1ps

interface ipcp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       first_of_string;

  modport source (output valid, char_byte, first_of_string, input ready);
  modport sink (input valid, char_byte, first_of_string, output ready);
endinterface

interface ipcp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] address;
  logic [31:0] mask;
  logic [5:0]  prefix_length;
  logic [15:0] consumed_length;

  modport source (output valid, status, address, mask, prefix_length, consumed_length,
                  input ready);
  modport sink (input valid, status, address, mask, prefix_length, consumed_length,
                output ready);
endinterface

>>> src/ipv4_cidr_text_parser.sv
// Top level of the IPv4 dotted-decimal text parser with optional CIDR prefix.
//
// Characters arrive one per beat on the in_i channel; a beat with
// first_of_string set starts a new parse. The parse ends with one result
// beat on out_o carrying status, address, mask, prefix length and the
// number of characters consumed; bytes after that are dropped until the
// next first_of_string. Beats that end nothing produce no result.
// A character beat is captured in an input register, and once the result
// register can take a result, a single pass of decimal accumulate and compare
// logic updates the parse state and, when the text ends, loads the result
// register. A result therefore becomes valid after its terminating character
// has passed through the input register and then the result register; one
// character is taken every cycle while the receiver keeps up.
// The result register is a one-deep output stage. While a result waits to
// be taken, processing pauses: the input register still takes one more
// character and holds it, then in_i.ready drops until the result is taken.
// prefix_mode_i is written when prefix_mode_we_i is high; it resets to 1
// (address, slash, prefix length expected). Reset empties both registers
// and returns the parser to waiting for the first character of a text.
`timescale 1ns / 1ps

module ipv4_cidr_text_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 prefix_mode_we_i,
  input  logic                 prefix_mode_i,
  ipcp_char_if.sink            in_i,
  ipcp_result_if.source        out_o
);
  import ipcp_pkg::*;

  logic         prefix_mode_q;
  logic         in_valid_q;
  logic [7:0]   char_q;
  logic         first_q;
  parse_state_t state_q, state_d;
  logic         emit;
  result_t      step_result;
  logic         out_valid_q;
  result_t      result_q;
  logic         proc_fire;

  // The buffered character is processed whenever the result register can
  // take a possible result: it is empty or is being emptied this cycle.
  assign proc_fire = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_mode_q <= 1'b1;
    end else if (prefix_mode_we_i) begin
      prefix_mode_q <= prefix_mode_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q  <= in_i.char_byte;
      first_q <= in_i.first_of_string;
    end
  end

  ipcp_step u_step (
    .state_i           (state_q),
    .char_byte_i       (char_q),
    .first_of_string_i (first_q),
    .prefix_mode_i     (prefix_mode_q),
    .state_o           (state_d),
    .emit_o            (emit),
    .result_o          (step_result)
  );

  // Parse state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (proc_fire) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && emit) begin
      result_q <= step_result;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = result_q.status;
  assign out_o.address         = result_q.address;
  assign out_o.mask            = result_q.mask;
  assign out_o.prefix_length   = result_q.prefix_length;
  assign out_o.consumed_length = result_q.consumed_length;

  // A failed parse never reports an address, mask or length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.status != ST_OK)) |->
      ((result_q.address == 32'd0) && (result_q.mask == 32'd0) &&
       (result_q.consumed_length == 16'd0)))
    else $error("error result carries payload");

  // A good result has consumed at least one character and a legal prefix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.status == ST_OK)) |->
      ((result_q.consumed_length != 16'd0) && (result_q.prefix_length <= PrefixMax)))
    else $error("good result with impossible length");

  // A buffered character that cannot be processed stays buffered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc_fire) |=> (in_valid_q && $stable(char_q) && $stable(first_q)))
    else $error("stalled character lost");

  // Every emitted result leaves the parser idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && emit) |=> (state_q.phase == PH_IDLE) && out_valid_q)
    else $error("result emitted without ending the parse");

endmodule

>>> src/ipcp_step.sv
// Next-state and result logic for one character of the parse.
`timescale 1ns / 1ps

module ipcp_step (
  input  ipcp_pkg::parse_state_t state_i,
  input  logic [7:0]             char_byte_i,
  input  logic                   first_of_string_i,
  input  logic                   prefix_mode_i,
  output ipcp_pkg::parse_state_t state_o,
  output logic                   emit_o,
  output ipcp_pkg::result_t      result_o
);
  import ipcp_pkg::*;

  always_comb begin
    parse_state_t w;
    logic         live;
    logic         is_digit;
    logic [3:0]   digit;
    logic [11:0]  part_next;
    logic [8:0]   prefix_next;

    w        = state_i;
    emit_o   = 1'b0;
    result_o = '0;
    live     = 1'b1;
    is_digit = (char_byte_i >= CharZero) && (char_byte_i <= CharNine);
    digit    = char_byte_i[3:0];

    if (first_of_string_i) begin
      w            = StateReset;
      w.char_count = 16'd1;
      w.phase      = PH_ADDR;
    end else if ((w.phase != PH_ADDR) && (w.phase != PH_PREFIX)) begin
      live = 1'b0;
    end else if (w.char_count != CountMax) begin
      w.char_count = w.char_count + 16'd1;
    end

    part_next   = {3'd0, w.part_acc} * 12'd10 + {8'd0, digit};
    prefix_next = {3'd0, w.prefix_acc} * 9'd10 + {5'd0, digit};

    if (live) begin
      case (w.phase)
        PH_ADDR: begin
          if (w.digit_expected) begin
            if (!is_digit) begin
              emit_o          = 1'b1;
              result_o.status = ST_DIGIT_EXP;
              w.phase         = PH_IDLE;
            end else begin
              w.part_acc       = {5'd0, digit};
              w.digit_expected = 1'b0;
            end
          end else if (is_digit) begin
            w.part_acc = (part_next > {3'd0, PartSat}) ? PartSat : part_next[8:0];
          end else if (char_byte_i == CharDot) begin
            if (w.parts_done == LastPart) begin
              emit_o          = 1'b1;
              result_o.status = ST_TOO_MANY;
              w.phase         = PH_IDLE;
            end else if (w.part_acc > PartMax) begin
              emit_o          = 1'b1;
              result_o.status = ST_PART_OVER;
              w.phase         = PH_IDLE;
            end else begin
              w.upper_addr     = {w.upper_addr[15:0], w.part_acc[7:0]};
              w.parts_done     = w.parts_done + 2'd1;
              w.part_acc       = 9'd0;
              w.digit_expected = 1'b1;
            end
          end else if (w.parts_done != LastPart) begin
            emit_o          = 1'b1;
            result_o.status = ST_TOO_FEW;
            w.phase         = PH_IDLE;
          end else if (w.part_acc > PartMax) begin
            emit_o          = 1'b1;
            result_o.status = ST_PART_OVER;
            w.phase         = PH_IDLE;
          end else if (!prefix_mode_i) begin
            emit_o                   = 1'b1;
            result_o.status          = ST_OK;
            result_o.address         = {w.upper_addr, w.part_acc[7:0]};
            result_o.mask            = 32'hffff_ffff;
            result_o.prefix_length   = PrefixMax;
            result_o.consumed_length = w.char_count;
            w.phase                  = PH_IDLE;
          end else if (char_byte_i != CharSlash) begin
            emit_o          = 1'b1;
            result_o.status = ST_NO_SLASH;
            w.phase         = PH_IDLE;
          end else begin
            w.prefix_acc = 6'd0;
            w.phase      = PH_PREFIX;
          end
        end
        PH_PREFIX: begin
          if (is_digit) begin
            w.prefix_acc = (prefix_next > {3'd0, PrefixSat}) ? PrefixSat : prefix_next[5:0];
          end else if (w.prefix_acc > PrefixMax) begin
            emit_o          = 1'b1;
            result_o.status = ST_PREFIX_OVER;
            w.phase         = PH_IDLE;
          end else begin
            emit_o                   = 1'b1;
            result_o.status          = ST_OK;
            result_o.address         = {w.upper_addr, w.part_acc[7:0]};
            result_o.mask            = (w.prefix_acc == 6'd0) ? 32'd0 :
                                       (32'hffff_ffff << (PrefixMax - w.prefix_acc));
            result_o.prefix_length   = w.prefix_acc;
            result_o.consumed_length = w.char_count;
            w.phase                  = PH_IDLE;
          end
        end
        default: ;
      endcase
    end

    state_o = w;
  end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the IPv4 dotted-decimal text parser with CIDR prefix.
`timescale 1ns / 1ps

import ipcp_pkg::*;

// Keeps a cycle-free model of the parser and the queue of results it should produce.
class parse_scoreboard;
  parse_state_t st;
  logic         prefix_mode;
  result_t      expected_results[$];
  int unsigned  failures;

  function new();
    st          = StateReset;
    prefix_mode = 1'b1;
    failures    = 0;
  endfunction

  function void set_prefix_mode(logic mode);
    prefix_mode = mode;
  endfunction

  function void log_failure(string what);
    failures++;
    if (failures <= 10) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
  endfunction

  // A text has ended: queue its result and go back to waiting for a start.
  function void finish_text(status_e status, logic [31:0] address, logic [31:0] mask,
                            logic [5:0] plen, logic [15:0] count);
    result_t r;
    r.status          = status;
    r.address         = address;
    r.mask            = mask;
    r.prefix_length   = plen;
    r.consumed_length = count;
    expected_results.push_back(r);
    st.phase = PH_IDLE;
  endfunction

  // Advances the model by one accepted character beat.
  function void note_char(logic [7:0] c, logic first);
    int unsigned v;
    logic        is_digit;
    logic [3:0]  digit;
    logic [31:0] mask;
    is_digit = (c >= CharZero) && (c <= CharNine);
    digit    = 4'(c - CharZero);
    if (first) begin
      st            = StateReset;
      st.char_count = 16'd1;
      st.phase      = PH_ADDR;
    end else begin
      if (st.phase != PH_ADDR && st.phase != PH_PREFIX) return;
      if (st.char_count < CountMax) st.char_count++;
    end

    if (st.phase == PH_ADDR) begin
      if (st.digit_expected) begin
        if (!is_digit) begin
          finish_text(ST_DIGIT_EXP, '0, '0, '0, '0);
          return;
        end
        st.part_acc       = 9'(digit);
        st.digit_expected = 1'b0;
        return;
      end
      if (is_digit) begin
        v = 32'(st.part_acc) * 10 + 32'(digit);
        st.part_acc = (v > 32'(PartSat)) ? PartSat : 9'(v);
        return;
      end
      if (c == CharDot) begin
        if (st.parts_done >= LastPart) begin
          finish_text(ST_TOO_MANY, '0, '0, '0, '0);
          return;
        end
        if (st.part_acc > PartMax) begin
          finish_text(ST_PART_OVER, '0, '0, '0, '0);
          return;
        end
        st.upper_addr     = {st.upper_addr[15:0], st.part_acc[7:0]};
        st.parts_done     = st.parts_done + 2'd1;
        st.part_acc       = '0;
        st.digit_expected = 1'b1;
        return;
      end
      // Any other byte ends the address.
      if (st.parts_done != LastPart) begin
        finish_text(ST_TOO_FEW, '0, '0, '0, '0);
        return;
      end
      if (st.part_acc > PartMax) begin
        finish_text(ST_PART_OVER, '0, '0, '0, '0);
        return;
      end
      if (!prefix_mode) begin
        finish_text(ST_OK, {st.upper_addr, st.part_acc[7:0]}, '1, PrefixMax, st.char_count);
        return;
      end
      if (c != CharSlash) begin
        finish_text(ST_NO_SLASH, '0, '0, '0, '0);
        return;
      end
      st.prefix_acc = '0;
      st.phase      = PH_PREFIX;
      return;
    end

    // Prefix length: any non-digit, a dot included, ends it.
    if (is_digit) begin
      v = 32'(st.prefix_acc) * 10 + 32'(digit);
      st.prefix_acc = (v > 32'(PrefixSat)) ? PrefixSat : 6'(v);
      return;
    end
    if (st.prefix_acc > PrefixMax) begin
      finish_text(ST_PREFIX_OVER, '0, '0, '0, '0);
      return;
    end
    mask = (st.prefix_acc == 6'd0) ? 32'h0 : (32'hffff_ffff << (6'd32 - st.prefix_acc));
    finish_text(ST_OK, {st.upper_addr, st.part_acc[7:0]}, mask, st.prefix_acc,
                st.char_count);
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      log_failure($sformatf("result with nothing expected: status %0d addr %08h",
                            got.status, got.address));
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status || got.address !== want.address ||
        got.mask !== want.mask || got.prefix_length !== want.prefix_length ||
        got.consumed_length !== want.consumed_length) begin
      log_failure($sformatf({"expected status %0d addr %08h mask %08h plen %0d len %0d, ",
                             "got status %0d addr %08h mask %08h plen %0d len %0d"},
                            want.status, want.address, want.mask, want.prefix_length,
                            want.consumed_length, got.status, got.address, got.mask,
                            got.prefix_length, got.consumed_length));
    end
  endfunction

  function void close_out();
    if (expected_results.size() != 0) begin
      log_failure($sformatf("%0d expected results never arrived", expected_results.size()));
    end
  endfunction
endclass

module testbench;

  localparam int unsigned HalfPeriod    = 5;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned MaxIdle       = 17;
  // A result passes the input and result registers after the terminating beat; allow slack.
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned WatchdogLimit = 2000;

  logic clk = 1'b0;
  logic rst_n;
  logic prefix_mode_we;
  logic prefix_mode;

  ipcp_char_if   chars ();
  ipcp_result_if results ();

  ipv4_cidr_text_parser dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .prefix_mode_we_i (prefix_mode_we),
    .prefix_mode_i    (prefix_mode),
    .in_i             (chars),
    .out_o            (results)
  );

  parse_scoreboard board = new();

  // When set, the side concerned runs without gaps until it flips back.
  bit          send_steady = 1'b0;
  bit          take_steady = 1'b0;
  int unsigned quiet_cycles = 0;

  always #(HalfPeriod) clk = ~clk;

  // The run is abandoned if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((chars.valid && chars.ready) || (results.valid && results.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one character beat after a random gap and waits until it is taken.
  task automatic send_char(input logic [7:0] c, input logic first, input logic no_idle);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) send_steady = !send_steady;
    gap = (no_idle || send_steady) ? 0 : $urandom_range(0, MaxIdle);
    repeat (gap) begin
      @(negedge clk);
      chars.valid <= 1'b0;
    end
    @(negedge clk);
    chars.valid           <= 1'b1;
    chars.char_byte       <= c;
    chars.first_of_string <= first;
    do @(posedge clk); while (chars.ready !== 1'b1);
    board.note_char(c, first);
  endtask

  task automatic send_text(input string s, input logic restart, input logic no_idle);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], restart && (i == 0), no_idle);
    end
  endtask

  function automatic void put_text(ref logic [7:0] buffer[$], input string s);
    for (int i = 0; i < s.len(); i++) buffer.push_back(s[i]);
  endfunction

  task automatic write_prefix_mode(input logic mode);
    @(negedge clk);
    prefix_mode_we <= 1'b1;
    prefix_mode    <= mode;
    @(negedge clk);
    prefix_mode_we <= 1'b0;
    board.set_prefix_mode(mode);
  endtask

  // Stops offering beats and lets every outstanding result come back.
  task automatic drain();
    @(negedge clk);
    chars.valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Mostly well-formed texts with random content, some cut short or broken,
  // and a little raw noise.
  task automatic run_random_phase(input logic mode, input int unsigned budget);
    logic [7:0]  text[$];
    logic [7:0]  b;
    int unsigned sent;
    int unsigned kind;
    int unsigned nparts;
    int unsigned sel;
    bit          with_prefix;
    sent = 0;
    write_prefix_mode(mode);
    while (sent < budget) begin
      text.delete();
      kind = $urandom_range(0, 11);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_char(8'($urandom), $urandom_range(0, 3) == 0, 1'b0);
          sent++;
        end
        continue;
      end
      nparts = (kind == 1) ? $urandom_range(1, 6) : 4;
      for (int p = 0; p < nparts; p++) begin
        if (p != 0) text.push_back(CharDot);
        sel = $urandom_range(0, 23);
        if (sel == 0) begin
          // An empty part: a digit is missing here.
        end else if (sel == 1) begin
          put_text(text, $sformatf("%0d", $urandom_range(256, 99999)));
        end else if (sel == 2) begin
          put_text(text, $sformatf("00%0d", $urandom_range(0, 255)));
        end else if (sel < 7) begin
          put_text(text, sel[0] ? "255" : "0");
        end else begin
          put_text(text, $sformatf("%0d", $urandom_range(0, 255)));
        end
      end
      with_prefix = mode ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 3) == 0);
      if (with_prefix) begin
        text.push_back(CharSlash);
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
          // An empty prefix counts as zero.
        end else if (sel == 1) begin
          put_text(text, $sformatf("%0d", $urandom_range(33, 9999)));
        end else if (sel == 2) begin
          put_text(text, $sformatf("0%0d", $urandom_range(0, 32)));
        end else begin
          put_text(text, $sformatf("%0d", $urandom_range(0, 32)));
        end
      end
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
        // Cut the text short so that the next start interrupts it.
        if (text.size() > 1) text = text[0:$urandom_range(0, text.size() - 2)];
      end else if (with_prefix && sel < 4) begin
        text.push_back(CharDot);
      end else begin
        do b = 8'($urandom);
        while ((b >= CharZero && b <= CharNine) || b == CharDot);
        text.push_back(b);
      end
      if (text.size() == 0) continue;
      for (int i = 0; i < text.size(); i++) send_char(text[i], i == 0, 1'b0);
      sent += text.size();
      // Bytes after the end of a text are dropped by the parser.
      repeat ($urandom_range(0, 2)) send_char(8'($urandom), 1'b0, 1'b0);
    end
    drain();
  endtask

  // Result side: stalls at random, then takes one beat and checks it.
  initial begin : result_taker
    result_t     got;
    int unsigned stall;
    results.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 29) == 0) take_steady = !take_steady;
      stall = take_steady ? 0 : $urandom_range(0, MaxIdle);
      repeat (stall) begin
        @(negedge clk);
        results.ready <= 1'b0;
      end
      @(negedge clk);
      results.ready <= 1'b1;
      do @(posedge clk); while (results.valid !== 1'b1);
      got.status          = status_e'(results.status);
      got.address         = results.address;
      got.mask            = results.mask;
      got.prefix_length   = results.prefix_length;
      got.consumed_length = results.consumed_length;
      board.check_result(got);
    end
  end

  initial begin : stimulus
    chars.valid           = 1'b0;
    chars.char_byte       = '0;
    chars.first_of_string = 1'b0;
    prefix_mode_we        = 1'b0;
    prefix_mode           = 1'b1;
    rst_n                 = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Prefix mode: every status, the field extremes and the odd corners.
    write_prefix_mode(1'b1);
    send_text("x9.", 1'b0, 1'b0);                 // no start seen yet, all dropped
    send_text("0.0.0.0/0 ", 1'b1, 1'b0);
    send_text("255.255.255.255/32,", 1'b1, 1'b0);
    send_text("10.1.2.3/ ", 1'b1, 1'b0);          // empty prefix gives length zero
    send_text("1.2.3.4/33 ", 1'b1, 1'b0);
    send_text("1.2.3.4/8.", 1'b1, 1'b0);          // a dot ends the prefix
    send_text(".1.2.3/8 ", 1'b1, 1'b0);
    send_text("1.2.3.4.5/8 ", 1'b1, 1'b0);
    send_text("256.1.1.1/8 ", 1'b1, 1'b0);
    send_text("9.9.9.4000/8 ", 1'b1, 1'b0);       // fourth part over range
    send_text("1.2.3/8 ", 1'b1, 1'b0);
    send_text("1.2.3.4 ", 1'b1, 1'b0);
    send_text("00012.34.5.6/0024 ", 1'b1, 1'b0);
    send_text("zz9", 1'b0, 1'b0);                 // after a result, dropped
    send_text("1.2.3", 1'b1, 1'b0);               // interrupted by the next start
    send_text("4.3.2.1/16 ", 1'b1, 1'b0);
    send_text("1.2.3.4/999999x", 1'b1, 1'b0);     // prefix saturates
    drain();

    // Bare address mode.
    write_prefix_mode(1'b0);
    send_text("192.168.0.1 ", 1'b1, 1'b0);
    send_text("1.2.3.4/8 ", 1'b1, 1'b0);          // the slash simply ends the address
    send_text("1.2.3.300 ", 1'b1, 1'b0);
    send_text("1.2.3 ", 1'b1, 1'b0);
    send_text("a", 1'b1, 1'b0);
    drain();

    run_random_phase(1'b1, 110);
    run_random_phase(1'b0, 100);
    run_random_phase(1'b1, 100);
    run_random_phase(1'b0, 100);

    board.close_out();
    if (board.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
